@@ rtl/core/rpse_pkg.sv @@
`timescale 1ns / 1ps
// shared types and constants of the random pause speed envelope
// no dependencies

package rpse_pkg;

  typedef logic [1:0] phase_t;

  localparam phase_t PH_NORMAL   = 2'd0;
  localparam phase_t PH_SLOWING  = 2'd1;
  localparam phase_t PH_STOPPED  = 2'd2;
  localparam phase_t PH_RESUMING = 2'd3;

  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 3;
  localparam int CHANCE_W   = 7;
  localparam int RND_W      = 7;
  localparam int RAMP_W     = 24;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_CHECK_INTERVAL = 3'd0;
  localparam cfg_idx_t REG_MIN_STOP_GAP   = 3'd1;
  localparam cfg_idx_t REG_STOP_PCT       = 3'd2;
  localparam cfg_idx_t REG_SLOW_DOWN_TIME = 3'd3;
  localparam cfg_idx_t REG_STOP_HOLD_TIME = 3'd4;
  localparam cfg_idx_t REG_SPEED_UP_TIME  = 3'd5;

  localparam logic [CFG_DATA_W-1:0] RST_CHECK_INTERVAL = 32'd1000;
  localparam logic [CFG_DATA_W-1:0] RST_MIN_STOP_GAP   = 32'd10000;
  localparam logic [CHANCE_W-1:0]   RST_STOP_PCT       = 7'd10;
  localparam logic [RAMP_W-1:0]     RST_SLOW_DOWN_TIME = 24'd1000;
  localparam logic [CFG_DATA_W-1:0] RST_STOP_HOLD_TIME = 32'd2000;
  localparam logic [RAMP_W-1:0]     RST_SPEED_UP_TIME  = 24'd1000;

endpackage

@@ rtl/core/random_pause_speed_envelope.sv @@
`timescale 1ns / 1ps
// random pause speed envelope: speed factor and phase from one time sample per transaction
// depends on rpse_pkg

// Each input transaction is one time sample (timestamp, random-mode flag, random draw); each
// produces exactly one result transaction with the speed factor (2^FRAC_BITS means full speed)
// and the phase after the sample. With random mode clear the block reports normal phase at full
// speed. In random mode a stop check runs every check_interval ticks while normal; if the gap
// since the last stop is at least min_stop_gap and the draw is below the stop percentage, the
// speed ramps down over slow_down_time ticks, holds at zero for stop_hold_time ticks and ramps
// back up over speed_up_time ticks. A transaction is taken only while the sequencer is idle;
// it then passes through the check and done states with random mode clear, through check,
// phase and done in random mode outside a ramp, and through check, phase, divide and done
// during a ramp, where the ramp fraction comes out of a bit-serial restoring divider producing
// one quotient bit per cycle. The next sample is accepted only once the result is loaded. A
// finished result sits in an output register, so the next sample is accepted while the
// previous result is still stalled. Configuration writes are always ready and should only be
// made while no transaction is in flight.

module random_pause_speed_envelope
  import rpse_pkg::*;
#(
  parameter int TIME_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  // input samples
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [TIME_WIDTH-1:0]  in_time_now,
  input  logic                   in_random_mode,
  input  logic [RND_W-1:0]       in_random_value,
  // results
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [FRAC_BITS:0]     out_speed_factor,
  output logic [1:0]             out_phase,
  // register writes
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  localparam int SPW   = FRAC_BITS + 1;
  localparam int CMPW  = (TIME_WIDTH > CFG_DATA_W) ? TIME_WIDTH : CFG_DATA_W;
  localparam int CNT_W = $clog2(FRAC_BITS);

  localparam logic [SPW-1:0] ONE = SPW'(1) << FRAC_BITS;

  // sequencer codes
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_CHECK = 3'd1;
  localparam logic [2:0] ST_PHASE = 3'd2;
  localparam logic [2:0] ST_DIV   = 3'd3;
  localparam logic [2:0] ST_DONE  = 3'd4;

  // configuration registers
  logic [CFG_DATA_W-1:0] check_interval_r;
  logic [CFG_DATA_W-1:0] min_stop_gap_r;
  logic [CHANCE_W-1:0]   stop_pct_r;
  logic [RAMP_W-1:0]     slow_down_time_r;
  logic [CFG_DATA_W-1:0] stop_hold_time_r;
  logic [RAMP_W-1:0]     speed_up_time_r;

  // sequencer and captured sample
  logic [2:0]            state_r, state_nxt;
  logic [TIME_WIDTH-1:0] now_r, now_nxt;
  logic                  mode_r, mode_nxt;
  logic [RND_W-1:0]      rnd_r, rnd_nxt;

  // envelope state
  phase_t                phase_r, phase_nxt;
  logic [TIME_WIDTH-1:0] phase_start_r, phase_start_nxt;
  logic [TIME_WIDTH-1:0] last_check_r, last_check_nxt;
  logic [TIME_WIDTH-1:0] last_trigger_r, last_trigger_nxt;

  // bit-serial divider
  logic [RAMP_W-1:0]     rem_r, rem_nxt;
  logic [RAMP_W-1:0]     div_r, div_nxt;
  logic [FRAC_BITS-1:0]  quo_r, quo_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;

  // result
  logic [SPW-1:0]        spd_r, spd_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [SPW-1:0]        out_speed_r, out_speed_nxt;
  phase_t                out_phase_r, out_phase_nxt;

  // wrapped time differences, then widened for comparison with the registers
  logic [TIME_WIDTH-1:0] d_check, d_trigger, d_phase;
  logic [CMPW-1:0]       e_check, e_trigger, e_phase;
  logic [RAMP_W-1:0]     ramp_len;
  logic [RAMP_W:0]       rem_dbl;
  logic [RAMP_W:0]       rem_sub;
  logic                  qbit;
  logic [FRAC_BITS-1:0]  quo_fin;

  assign d_check   = now_r - last_check_r;
  assign d_trigger = now_r - last_trigger_r;
  assign d_phase   = now_r - phase_start_r;
  assign e_check   = CMPW'(d_check);
  assign e_trigger = CMPW'(d_trigger);
  assign e_phase   = CMPW'(d_phase);
  assign ramp_len  = (phase_r == PH_SLOWING) ? slow_down_time_r : speed_up_time_r;

  // one restoring step: remainder stays below the divisor
  assign rem_dbl = {rem_r, 1'b0};
  assign rem_sub = rem_dbl - {1'b0, div_r};
  assign qbit    = (rem_dbl >= {1'b0, div_r});
  assign quo_fin = {quo_r[FRAC_BITS-2:0], qbit};

  assign in_stall         = (state_r != ST_IDLE);
  assign out_valid        = out_valid_r;
  assign out_speed_factor = out_speed_r;
  assign out_phase        = out_phase_r;
  assign cfg_ready        = 1'b1;

  always_comb begin
    state_nxt        = state_r;
    now_nxt          = now_r;
    mode_nxt         = mode_r;
    rnd_nxt          = rnd_r;
    phase_nxt        = phase_r;
    phase_start_nxt  = phase_start_r;
    last_check_nxt   = last_check_r;
    last_trigger_nxt = last_trigger_r;
    rem_nxt          = rem_r;
    div_nxt          = div_r;
    quo_nxt          = quo_r;
    cnt_nxt          = cnt_r;
    spd_nxt          = spd_r;
    out_valid_nxt    = out_valid_r;
    out_speed_nxt    = out_speed_r;
    out_phase_nxt    = out_phase_r;

    // result taken downstream
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          now_nxt   = in_time_now;
          mode_nxt  = in_random_mode;
          rnd_nxt   = in_random_value;
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (!mode_r) begin
          // forced normal, check and trigger history kept
          phase_nxt       = PH_NORMAL;
          phase_start_nxt = '0;
          spd_nxt         = ONE;
          state_nxt       = ST_DONE;
        end else begin
          if (phase_r == PH_NORMAL && e_check >= CMPW'(check_interval_r)) begin
            last_check_nxt = now_r;
            if (e_trigger >= CMPW'(min_stop_gap_r) && rnd_r < stop_pct_r) begin
              phase_nxt        = PH_SLOWING;
              phase_start_nxt  = now_r;
              last_trigger_nxt = now_r;
            end
          end
          state_nxt = ST_PHASE;
        end
      end
      ST_PHASE: begin
        state_nxt = ST_DONE;
        case (phase_r)
          PH_NORMAL: begin
            spd_nxt = ONE;
          end
          PH_STOPPED: begin
            spd_nxt = '0;
            if (e_phase >= CMPW'(stop_hold_time_r)) begin
              phase_nxt       = PH_RESUMING;
              phase_start_nxt = now_r;
            end
          end
          default: begin
            // slowing or resuming ramp
            if (e_phase >= CMPW'(ramp_len)) begin
              if (phase_r == PH_SLOWING) begin
                spd_nxt         = '0;
                phase_nxt       = PH_STOPPED;
                phase_start_nxt = now_r;
              end else begin
                spd_nxt   = ONE;
                phase_nxt = PH_NORMAL;
              end
            end else begin
              rem_nxt   = e_phase[RAMP_W-1:0];
              div_nxt   = ramp_len;
              quo_nxt   = '0;
              cnt_nxt   = CNT_W'(FRAC_BITS - 1);
              state_nxt = ST_DIV;
            end
          end
        endcase
      end
      ST_DIV: begin
        rem_nxt = qbit ? rem_sub[RAMP_W-1:0] : rem_dbl[RAMP_W-1:0];
        quo_nxt = quo_fin;
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          if (phase_r == PH_SLOWING) begin
            spd_nxt = ONE - SPW'(quo_fin);
          end else begin
            spd_nxt = SPW'(quo_fin);
          end
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        // wait for a free output register
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_speed_nxt = spd_r;
          out_phase_nxt = phase_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= ST_IDLE;
      phase_r          <= PH_NORMAL;
      phase_start_r    <= '0;
      last_check_r     <= '0;
      last_trigger_r   <= '0;
      out_valid_r      <= 1'b0;
      check_interval_r <= RST_CHECK_INTERVAL;
      min_stop_gap_r   <= RST_MIN_STOP_GAP;
      stop_pct_r       <= RST_STOP_PCT;
      slow_down_time_r <= RST_SLOW_DOWN_TIME;
      stop_hold_time_r <= RST_STOP_HOLD_TIME;
      speed_up_time_r  <= RST_SPEED_UP_TIME;
    end else begin
      state_r        <= state_nxt;
      phase_r        <= phase_nxt;
      phase_start_r  <= phase_start_nxt;
      last_check_r   <= last_check_nxt;
      last_trigger_r <= last_trigger_nxt;
      out_valid_r    <= out_valid_nxt;
      if (cfg_valid) begin
        unique case (cfg_index)
          REG_CHECK_INTERVAL: check_interval_r <= cfg_data;
          REG_MIN_STOP_GAP:   min_stop_gap_r   <= cfg_data;
          REG_STOP_PCT:       stop_pct_r       <= cfg_data[CHANCE_W-1:0];
          REG_SLOW_DOWN_TIME: slow_down_time_r <= cfg_data[RAMP_W-1:0];
          REG_STOP_HOLD_TIME: stop_hold_time_r <= cfg_data;
          REG_SPEED_UP_TIME:  speed_up_time_r  <= cfg_data[RAMP_W-1:0];
          default: ;
        endcase
      end
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    now_r       <= now_nxt;
    mode_r      <= mode_nxt;
    rnd_r       <= rnd_nxt;
    rem_r       <= rem_nxt;
    div_r       <= div_nxt;
    quo_r       <= quo_nxt;
    cnt_r       <= cnt_nxt;
    spd_r       <= spd_nxt;
    out_speed_r <= out_speed_nxt;
    out_phase_r <= out_phase_nxt;
  end

  // speed never exceeds full scale
  a_speed_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_speed_factor <= ONE))
    else $error("speed factor above full scale");

  // normal phase always reports full speed
  a_normal_full: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_phase == PH_NORMAL) |-> (out_speed_factor == ONE))
    else $error("normal phase without full speed");

  // stopped phase always reports zero speed
  a_stopped_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_phase == PH_STOPPED) |-> (out_speed_factor == '0))
    else $error("stopped phase with nonzero speed");

  // one transaction in flight: an accepted sample blocks the next one
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second sample accepted while busy");

endmodule

@@ dv/tb_random_pause_speed_envelope.sv @@
`timescale 1ns / 1ps
// self-checking testbench for random_pause_speed_envelope: predicts speed factor and phase
// for every time sample and compares each result transaction in order; depends on rpse_pkg

module tb_random_pause_speed_envelope;
  import rpse_pkg::*;

  localparam int          FRAC_W      = 16;
  localparam logic [16:0] SPEED_ONE   = 17'd1 << FRAC_W;
  localparam int          HOLD_CYCLES = 300;   // long receiver hold-off
  localparam int          QUIET_LIMIT = 3000;  // cycles with no transaction before giving up
  localparam int          SHOW_LIMIT  = 10;
  // index with no register behind it
  localparam cfg_idx_t    REG_UNUSED  = 3'd7;

  typedef struct packed {
    logic [31:0] stamp;
    logic        mode;
    logic [6:0]  draw;
  } sample_t;

  typedef struct packed {
    logic [16:0] speed;
    phase_t      phase;
  } envelope_t;

  logic        clk;
  logic        rst_n           = 1'b0;
  logic        in_valid        = 1'b0;
  logic        in_stall;
  logic [31:0] in_time_now     = '0;
  logic        in_random_mode  = 1'b0;
  logic [6:0]  in_random_value = '0;
  logic        out_valid;
  logic        out_stall       = 1'b0;
  logic [16:0] out_speed_factor;
  logic [1:0]  out_phase;
  logic        cfg_valid       = 1'b0;
  logic        cfg_ready;
  cfg_idx_t    cfg_index       = '0;
  logic [31:0] cfg_data        = '0;

  random_pause_speed_envelope DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_time_now      (in_time_now),
    .in_random_mode   (in_random_mode),
    .in_random_value  (in_random_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_speed_factor (out_speed_factor),
    .out_phase        (out_phase),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // stimulus and scoreboard storage
  sample_t     samples_q[$];        // time samples waiting to be driven
  envelope_t   envelope_q[$];       // predicted speed/phase, oldest first
  bit          sample_taken = 1'b0; // input transaction at the last rising edge
  bit          calm         = 1'b0; // no idling on either side
  int          hold_asks    = 0;    // bumped to request one long receiver hold-off
  int          mismatches   = 0;
  logic [31:0] sample_clock = '0;   // running timestamp for generated samples

  // register shadow, written when a config transaction is accepted
  logic [31:0] chk_interval = RST_CHECK_INTERVAL;
  logic [31:0] stop_gap     = RST_MIN_STOP_GAP;
  logic [6:0]  chance       = RST_STOP_PCT;
  logic [23:0] slow_ticks   = RST_SLOW_DOWN_TIME;
  logic [31:0] hold_ticks   = RST_STOP_HOLD_TIME;
  logic [23:0] rise_ticks   = RST_SPEED_UP_TIME;

  // envelope state as the block should hold it
  phase_t      env_phase = PH_NORMAL;
  logic [31:0] env_start = '0;
  logic [31:0] env_check = '0;
  logic [31:0] env_stop  = '0;

  // ---------------------------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------------------------

  // timestamps wrap, so every distance is taken modulo 2^32
  function automatic logic [31:0] ticks_since(input logic [31:0] now_t, input logic [31:0] from_t);
    return now_t - from_t;
  endfunction

  // truncated elapsed/length in 16-bit fraction; only called with elapsed < length
  function automatic logic [16:0] ramp_fraction(input logic [31:0] elapsed,
                                                input logic [23:0] len);
    logic [55:0] num;
    logic [55:0] quo;
    num = {8'd0, elapsed, 16'd0};
    quo = num / {32'd0, len};
    return quo[16:0];
  endfunction

  function automatic envelope_t envelope_step(input sample_t s);
    logic [31:0] elapsed;
    envelope_t   r;
    r.speed = SPEED_ONE;
    if (!s.mode) begin
      // random mode off: back to normal at full speed, check/stop history kept
      env_phase = PH_NORMAL;
      env_start = '0;
    end else begin
      // stop check only from normal phase and only once the interval has passed
      if (env_phase == PH_NORMAL && ticks_since(s.stamp, env_check) >= chk_interval) begin
        env_check = s.stamp;
        if (ticks_since(s.stamp, env_stop) >= stop_gap && s.draw < chance) begin
          env_phase = PH_SLOWING;
          env_start = s.stamp;
          env_stop  = s.stamp;
        end
      end
      // a fresh stop is evaluated right away with zero elapsed
      elapsed = ticks_since(s.stamp, env_start);
      case (env_phase)
        PH_NORMAL: begin
          r.speed = SPEED_ONE;
        end
        PH_SLOWING: begin
          if (elapsed >= slow_ticks) begin
            // also covers a zero-length ramp, no divide then
            r.speed   = '0;
            env_phase = PH_STOPPED;
            env_start = s.stamp;
          end else begin
            r.speed = SPEED_ONE - ramp_fraction(elapsed, slow_ticks);
          end
        end
        PH_STOPPED: begin
          // the step that ends the hold still reports zero speed
          if (elapsed >= hold_ticks) begin
            env_phase = PH_RESUMING;
            env_start = s.stamp;
          end
          r.speed = '0;
        end
        default: begin
          if (elapsed >= rise_ticks) begin
            r.speed   = SPEED_ONE;
            env_phase = PH_NORMAL;
          end else begin
            r.speed = ramp_fraction(elapsed, rise_ticks);
          end
        end
      endcase
      if (r.speed > SPEED_ONE) r.speed = SPEED_ONE;
    end
    r.phase = env_phase;
    return r;
  endfunction

  // register write as the block sees it: masked to width, unknown index dropped
  function automatic void shadow_write(input cfg_idx_t idx, input logic [31:0] val);
    case (idx)
      REG_CHECK_INTERVAL: chk_interval = val;
      REG_MIN_STOP_GAP:   stop_gap     = val;
      REG_STOP_PCT:       chance       = val[6:0];
      REG_SLOW_DOWN_TIME: slow_ticks   = val[23:0];
      REG_STOP_HOLD_TIME: hold_ticks   = val;
      REG_SPEED_UP_TIME:  rise_ticks   = val[23:0];
      default: ;
    endcase
  endfunction

  function automatic void field_mismatch(input string field, input int unsigned want,
                                         input int unsigned got);
    mismatches++;
    if (mismatches <= SHOW_LIMIT)
      $display("%s mismatch: expected %0d, got %0d", field, want, got);
  endfunction

  // ---------------------------------------------------------------------------------------------
  // monitor: every transaction is sampled at the rising edge
  // ---------------------------------------------------------------------------------------------
  always @(posedge clk) begin
    envelope_t want;
    sample_taken = rst_n && in_valid && !in_stall;
    if (rst_n) begin
      if (cfg_valid && cfg_ready) shadow_write(cfg_index, cfg_data);
      // result side first; a result never belongs to a sample taken on the same edge
      if (out_valid && !out_stall) begin
        if (envelope_q.size() == 0) begin
          mismatches++;
          if (mismatches <= SHOW_LIMIT)
            $display("result with nothing pending: speed_factor %0d, phase %0d",
                     out_speed_factor, out_phase);
        end else begin
          want = envelope_q.pop_front();
          if (out_speed_factor !== want.speed)
            field_mismatch("speed_factor", want.speed, out_speed_factor);
          if (out_phase !== want.phase)
            field_mismatch("phase", want.phase, out_phase);
        end
      end
      if (sample_taken)
        envelope_q.push_back(envelope_step({in_time_now, in_random_mode, in_random_value}));
    end
  end

  // ---------------------------------------------------------------------------------------------
  // driver: pops samples at the falling edge, holds each one until its transaction
  // ---------------------------------------------------------------------------------------------
  always @(negedge clk) begin
    sample_t s;
    int      send_gap;
    if (!rst_n) begin
      send_gap = 0;
    end else if (in_valid && !sample_taken) begin
      // stalled: payload stays put
    end else if (send_gap > 0) begin
      in_valid <= 1'b0;
      send_gap--;
    end else if (samples_q.size() > 0) begin
      s = samples_q.pop_front();
      in_time_now     <= s.stamp;
      in_random_mode  <= s.mode;
      in_random_value <= s.draw;
      in_valid        <= 1'b1;
      // idle burst after this transaction
      if (!calm && $urandom_range(0, 5) == 0) send_gap = $urandom_range(1, 4);
    end else begin
      in_valid <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------------------------
  // receiver: random stall bursts plus a long hold-off on request
  // ---------------------------------------------------------------------------------------------
  always @(negedge clk) begin
    int hold_left;
    int stall_left;
    int hold_served;
    if (!rst_n) begin
      hold_left   = 0;
      stall_left  = 0;
      hold_served = 0;
    end else begin
      if (hold_served != hold_asks) begin
        hold_served = hold_asks;
        hold_left   = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else if (stall_left > 0) begin
        out_stall <= 1'b1;
        stall_left--;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        // stall burst, begun here and extended by stall_left
        out_stall <= 1'b1;
        stall_left = $urandom_range(0, 3);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------------------------
  // watchdog: too long without any transaction on any port
  // ---------------------------------------------------------------------------------------------
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("tb_random_pause_speed_envelope: done, errors");
    $finish;
  end

  // ---------------------------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------------------------
  task automatic add_sample(input logic [31:0] stamp, input logic mode, input logic [6:0] draw);
    samples_q.push_back('{stamp: stamp, mode: mode, draw: draw});
  endtask

  // timestamps advancing by random steps, with an occasional jump anywhere in the 32-bit range,
  // random mode mostly on
  task automatic queue_random(input int count, input logic [31:0] max_step);
    repeat (count) begin
      if ($urandom_range(0, 24) == 0)
        sample_clock = $urandom();
      else
        sample_clock = sample_clock + $urandom_range(0, max_step);
      add_sample(sample_clock, $urandom_range(0, 9) != 0, 7'($urandom_range(0, 99)));
    end
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [31:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_envelope(input logic [31:0] interval, input logic [31:0] gap,
                              input logic [31:0] pct, input logic [31:0] slow,
                              input logic [31:0] hold, input logic [31:0] rise);
    write_reg(REG_CHECK_INTERVAL, interval);
    write_reg(REG_MIN_STOP_GAP, gap);
    write_reg(REG_STOP_PCT, pct);
    write_reg(REG_SLOW_DOWN_TIME, slow);
    write_reg(REG_STOP_HOLD_TIME, hold);
    write_reg(REG_SPEED_UP_TIME, rise);
  endtask

  // every sample sent and every result back; one result per sample, so the block is idle
  task automatic drain();
    do @(posedge clk); while (samples_q.size() != 0 || in_valid || envelope_q.size() != 0);
  endtask

  // ---------------------------------------------------------------------------------------------
  // test sequence
  // ---------------------------------------------------------------------------------------------
  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: one full stop cycle walked through by hand
    add_sample(32'd0, 1'b0, 7'd0);          // mode off
    add_sample(32'd0, 1'b1, 7'd99);         // normal, no check yet
    add_sample(32'd999, 1'b1, 7'd0);        // interval not reached
    add_sample(32'd1000, 1'b1, 7'd0);       // check, but too soon after last stop
    add_sample(32'd10000, 1'b1, 7'd127);    // draw above range, no stop
    add_sample(32'd11000, 1'b1, 7'd100);    // draw just above range
    add_sample(32'd12000, 1'b1, 7'd9);      // stop begins, still full speed
    add_sample(32'd12001, 1'b1, 7'd0);
    add_sample(32'd12500, 1'b1, 7'd0);      // half way down
    add_sample(32'd12999, 1'b1, 7'd0);
    add_sample(32'd13000, 1'b1, 7'd0);      // reaches zero, stopped
    add_sample(32'd14999, 1'b1, 7'd0);
    add_sample(32'd15000, 1'b1, 7'd0);      // hold over, resuming at zero speed
    add_sample(32'd15001, 1'b1, 7'd0);
    add_sample(32'd15999, 1'b1, 7'd0);
    add_sample(32'd16000, 1'b1, 7'd0);      // back to normal
    add_sample(32'd16000, 1'b1, 7'd0);      // check with the gap not yet met
    add_sample(32'd22000, 1'b1, 7'd0);      // second stop
    add_sample(32'd22400, 1'b0, 7'd0);      // mode off in mid ramp
    add_sample(32'hFFFF_FFFF, 1'b1, 7'd0);  // stop at the top of the time range
    add_sample(32'd499, 1'b1, 7'd0);        // elapsed across the wrap
    add_sample(32'd999, 1'b1, 7'd0);
    add_sample(32'hFFFF_FFFF, 1'b0, 7'd127);
    drain();

    // short ramps and frequent checks; the receiver holds off mid-phase so the block backs up
    set_envelope(32'd4, 32'd25, 32'd40, 32'd20, 32'd15, 32'd20);
    queue_random(200, 32'd8);
    hold_asks++;
    drain();

    // no interval, no gap, chance past 100, unit ramps, no hold
    set_envelope(32'd0, 32'd0, 32'd127, 32'd1, 32'd0, 32'd1);
    queue_random(100, 32'd3);
    drain();

    // zero-length ramps end in the step they start
    set_envelope(32'd1, 32'd3, 32'd100, 32'd0, 32'd5, 32'd0);
    queue_random(80, 32'd6);
    drain();

    // all ones written everywhere: ramps cut to 24 bits, chance cut to zero;
    // a write to an unused index must change nothing
    set_envelope(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FF80, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                 32'hFFFF_FFFF);
    write_reg(REG_UNUSED, 32'd0);
    queue_random(60, 32'hFFFF_FFFF);
    drain();

    // longest ramps with huge time steps
    set_envelope(32'd0, 32'd0, 32'd100, 32'h00FF_FFFF, 32'h0100_0000, 32'h00FF_FFFF);
    queue_random(100, 32'h0080_0000);
    drain();

    // random settings
    repeat (3) begin
      set_envelope($urandom_range(0, 60), $urandom_range(0, 200), $urandom_range(0, 100),
                   $urandom_range(1, 80), $urandom_range(0, 80), $urandom_range(1, 80));
      queue_random(70, 32'd12);
      drain();
    end

    // last stretch at full rate on both sides
    calm = 1'b1;
    set_envelope(32'd2, 32'd12, 32'd60, 32'd9, 32'd6, 32'd11);
    queue_random(150, 32'd5);
    drain();

    // room for a stray late result
    repeat (40) @(posedge clk);
    if (mismatches == 0 && envelope_q.size() == 0) begin
      $display("tb_random_pause_speed_envelope: done, clean");
    end else begin
      $display("tb_random_pause_speed_envelope: done, errors");
    end
    $finish;
  end

endmodule
